// ----- rtl/dq_pkg.sv -----
// package for the double-ended queue: field widths, parameter defaults,
// opcode and status codes, and the control bundle handed to each cell row
// no dependencies
package dq_pkg;

  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned OPCODE_W    = 2;
  localparam int unsigned DEPTH_DEF   = 16;
  localparam int unsigned DATA_W_DEF  = 32;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH_BACK  = 2'd0,
    OP_PUSH_FRONT = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_BACK   = 2'd3
  } dq_opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_POP_EMPTY  = 2'd1,
    ST_PUSH_FULL  = 2'd2
  } dq_status_e;

  // shift_up: every cell takes its lower neighbor, the input word enters cell 0
  // shift_down: every cell takes its upper neighbor
  // load: the cell whose index equals the count takes the input word
  typedef struct packed {
    logic shift_up;
    logic shift_down;
    logic load;
  } dq_ctrl_t;

endpackage

// ----- rtl/dq_if.sv -----
// valid/ready channel interfaces for the double-ended queue
// depends on dq_pkg
interface dq_in_if #(
  parameter int unsigned VALUE_W = dq_pkg::VALUE_W
);
  logic                          valid;
  logic                          ready;
  logic [dq_pkg::OPCODE_W-1:0]   opcode;
  logic [VALUE_W-1:0]            value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface dq_out_if #(
  parameter int unsigned VALUE_W = dq_pkg::VALUE_W,
  parameter int unsigned CNT_W   = $clog2(dq_pkg::DEPTH_DEF + 1)
);
  logic                          valid;
  logic                          ready;
  logic [dq_pkg::STATUS_W-1:0]   status;
  logic [VALUE_W-1:0]            front_value;
  logic [VALUE_W-1:0]            back_value;
  logic [CNT_W-1:0]              entry_count;
  logic                          is_empty;

  modport source (output valid, output status, output front_value, output back_value,
                  output entry_count, output is_empty, input ready);
  modport sink   (input valid, input status, input front_value, input back_value,
                  input entry_count, input is_empty, output ready);
endinterface

// ----- rtl/dq_cell.sv -----
// one storage cell of a queue row: holds a word and takes it from a neighbor
// or from the input word as the row control says
// depends on dq_pkg
module dq_cell #(
  parameter int unsigned DATA_WIDTH = dq_pkg::DATA_W_DEF,
  parameter int unsigned CNT_W      = 5,
  parameter int unsigned INDEX      = 0
) (
  input  logic                  clk_i,
  input  dq_pkg::dq_ctrl_t      ctrl_i,
  input  logic [CNT_W-1:0]      count_i,
  input  logic [DATA_WIDTH-1:0] value_i,
  input  logic [DATA_WIDTH-1:0] lower_i,
  input  logic [DATA_WIDTH-1:0] upper_i,
  output logic [DATA_WIDTH-1:0] data_o
);
  import dq_pkg::*;

  logic [DATA_WIDTH-1:0] data_d, data_q;
  logic                  hit;

  assign hit = (count_i == CNT_W'(INDEX));

  always_comb begin
    data_d = data_q;
    priority if (ctrl_i.shift_up) begin
      data_d = lower_i;
    end else if (ctrl_i.shift_down) begin
      data_d = upper_i;
    end else if (ctrl_i.load && hit) begin
      data_d = value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// ----- rtl/dq_row.sv -----
// a row of queue cells ordered from one end of the queue; cell 0 is the end
// depends on dq_pkg and dq_cell
module dq_row #(
  parameter int unsigned DEPTH      = dq_pkg::DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = dq_pkg::DATA_W_DEF,
  parameter int unsigned CNT_W      = $clog2(DEPTH + 1)
) (
  input  logic                  clk_i,
  input  dq_pkg::dq_ctrl_t      ctrl_i,
  input  logic [CNT_W-1:0]      count_i,
  input  logic [DATA_WIDTH-1:0] value_i,
  output logic [DATA_WIDTH-1:0] head_o
);
  import dq_pkg::*;

  logic [DATA_WIDTH-1:0] cell_data [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] lower, upper;

    if (i == 0) begin : g_first
      assign lower = value_i;
    end else begin : g_mid_lo
      assign lower = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign upper = '0;
    end else begin : g_mid_hi
      assign upper = cell_data[i+1];
    end

    dq_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .CNT_W      (CNT_W),
      .INDEX      (i)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl_i),
      .count_i (count_i),
      .value_i (value_i),
      .lower_i (lower),
      .upper_i (upper),
      .data_o  (cell_data[i])
    );
  end

  assign head_o = cell_data[0];

endmodule

// ----- rtl/double_ended_queue_core.sv -----
// bounded double-ended queue built from two rows of shifting cells
//
// req_i carries one operation per transaction: opcode (push back, push front,
// pop front, pop back) and value. rsp_o returns exactly one transaction per
// operation: status (ok, pop on empty, push on full), front and back entries,
// entry count and empty flag, all as they stand after the operation.
// One row holds the entries ordered from the front, the other ordered from the
// back, so both ends sit in cell 0 of a row. A push at one end shifts that
// row up and loads the word into the other row at the cell given by the
// count; a pop shifts one row down.
// Latency: the result is valid on the cycle after the request transaction.
// Throughput: one operation per cycle while rsp_o is taken every cycle; the
// result register is the only stage, so req_i.ready follows rsp_o.ready when
// a result is held. When the receiver stalls, the result and the queue state
// hold and no new request is accepted.
// Reset clears the count and the result valid; cell contents are undefined
// until written and are never shown while not held.
// depends on dq_pkg, dq_if, dq_row, dq_cell
module double_ended_queue_core #(
  parameter int unsigned DEPTH      = dq_pkg::DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = dq_pkg::DATA_W_DEF,
  parameter int unsigned CNT_W      = $clog2(DEPTH + 1)
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  dq_in_if.sink    req_i,
  dq_out_if.source rsp_o
);
  import dq_pkg::*;

  logic [CNT_W-1:0]      count_d, count_q;
  logic                  out_valid_d, out_valid_q;
  dq_status_e            status_d, status_q;
  dq_opcode_e            opcode;
  logic                  accept, full, empty;
  dq_ctrl_t              front_ctrl, back_ctrl;
  logic [DATA_WIDTH-1:0] store_value, front_head, back_head;
  logic [DATA_WIDTH+VALUE_W-1:0] value_ext;
  logic [VALUE_W+DATA_WIDTH-1:0] front_ext, back_ext;

  assign opcode      = dq_opcode_e'(req_i.opcode);
  assign req_i.ready = !out_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;
  assign full        = (count_q == CNT_W'(DEPTH));
  assign empty       = (count_q == '0);

  assign value_ext   = {{DATA_WIDTH{1'b0}}, req_i.value};
  assign store_value = value_ext[DATA_WIDTH-1:0];

  always_comb begin
    front_ctrl  = '0;
    back_ctrl   = '0;
    count_d     = count_q;
    status_d    = status_q;
    out_valid_d = out_valid_q;
    if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (accept) begin
      out_valid_d = 1'b1;
      status_d    = ST_OK;
      unique case (opcode)
        OP_PUSH_BACK: begin
          if (full) begin
            status_d = ST_PUSH_FULL;
          end else begin
            back_ctrl.shift_up = 1'b1;
            front_ctrl.load    = 1'b1;
            count_d            = count_q + CNT_W'(1);
          end
        end
        OP_PUSH_FRONT: begin
          if (full) begin
            status_d = ST_PUSH_FULL;
          end else begin
            front_ctrl.shift_up = 1'b1;
            back_ctrl.load      = 1'b1;
            count_d             = count_q + CNT_W'(1);
          end
        end
        OP_POP_FRONT: begin
          if (empty) begin
            status_d = ST_POP_EMPTY;
          end else begin
            front_ctrl.shift_down = 1'b1;
            count_d               = count_q - CNT_W'(1);
          end
        end
        OP_POP_BACK: begin
          if (empty) begin
            status_d = ST_POP_EMPTY;
          end else begin
            back_ctrl.shift_down = 1'b1;
            count_d              = count_q - CNT_W'(1);
          end
        end
        default: begin
          status_d = ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
      status_q    <= ST_OK;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      status_q    <= status_d;
    end
  end

  dq_row #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .CNT_W      (CNT_W)
  ) u_front_row (
    .clk_i   (clk_i),
    .ctrl_i  (front_ctrl),
    .count_i (count_q),
    .value_i (store_value),
    .head_o  (front_head)
  );

  dq_row #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .CNT_W      (CNT_W)
  ) u_back_row (
    .clk_i   (clk_i),
    .ctrl_i  (back_ctrl),
    .count_i (count_q),
    .value_i (store_value),
    .head_o  (back_head)
  );

  assign front_ext = {{VALUE_W{1'b0}}, front_head};
  assign back_ext  = {{VALUE_W{1'b0}}, back_head};

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = status_q;
  assign rsp_o.front_value = empty ? '0 : front_ext[VALUE_W-1:0];
  assign rsp_o.back_value  = empty ? '0 : back_ext[VALUE_W-1:0];
  assign rsp_o.entry_count = count_q;
  assign rsp_o.is_empty    = empty;

endmodule
